FILE: design/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and the segment encoding for the seven-segment
// display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

   // operation codes carried by the func field
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // sign flag value that requests a minus bar
   localparam logic SIGN_MINUS = 1'b0;

   localparam int DECIMAL_DIGITS = 5;
   localparam int BUFFER_DEPTH   = 8;
   localparam int POS_WIDTH      = $clog2(BUFFER_DEPTH);

   localparam logic [7:0] MINUS_PATTERN = 8'h40;
   localparam logic [7:0] POINT_PATTERN = 8'h80;

   // reciprocal constants, exact floor division for any 16-bit value
   localparam logic [16:0] RECIP_10    = 17'd52429;
   localparam int          SHIFT_10    = 19;
   localparam logic [16:0] RECIP_100   = 17'd83887;
   localparam int          SHIFT_100   = 23;
   localparam logic [16:0] RECIP_1000  = 17'd67109;
   localparam int          SHIFT_1000  = 26;
   localparam logic [16:0] RECIP_10000 = 17'd107375;
   localparam int          SHIFT_10000 = 30;

   typedef logic [DECIMAL_DIGITS-1:0][3:0] digits_type;
   typedef logic [BUFFER_DEPTH-1:0][7:0]   buffer_type;

   // load request handed to the segment buffer
   typedef struct packed {
      logic       load;
      logic       sign_flag;
      digits_type digits;
   } load_req_type;

   // segment table for decimal digits
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0:    pat = 8'h3f;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5b;
         4'd3:    pat = 8'h4f;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6d;
         4'd6:    pat = 8'h7d;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7f;
         4'd9:    pat = 8'h6f;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

FILE: design/ssd_digit_split.sv
// ----------------------------------------------------------------------------
// ssd_digit_split
// Splits a 16-bit value into five decimal digits using parallel reciprocal
// multiplies and a small remainder step per lower digit.
// ----------------------------------------------------------------------------
module ssd_digit_split (
   input  logic [15:0]        number,
   output ssd_pkg::digits_type digits
);

   logic [32:0] prod_1;
   logic [32:0] prod_2;
   logic [32:0] prod_3;
   logic [32:0] prod_4;
   logic [12:0] quot_1;
   logic [9:0]  quot_2;
   logic [6:0]  quot_3;
   logic [2:0]  quot_4;

   // quotients by 10, 100, 1000 and 10000, all from the input value
   assign prod_1 = 33'(number) * 33'(ssd_pkg::RECIP_10);
   assign prod_2 = 33'(number) * 33'(ssd_pkg::RECIP_100);
   assign prod_3 = 33'(number) * 33'(ssd_pkg::RECIP_1000);
   assign prod_4 = 33'(number) * 33'(ssd_pkg::RECIP_10000);

   assign quot_1 = 13'(prod_1 >> ssd_pkg::SHIFT_10);
   assign quot_2 = 10'(prod_2 >> ssd_pkg::SHIFT_100);
   assign quot_3 = 7'(prod_3 >> ssd_pkg::SHIFT_1000);
   assign quot_4 = 3'(prod_4 >> ssd_pkg::SHIFT_10000);

   // lower digits are remainders after the next quotient, top is quot_4
   assign digits[0] = 4'(number - 16'(quot_1) * 16'd10);
   assign digits[1] = 4'(quot_1 - 13'(quot_2) * 13'd10);
   assign digits[2] = 4'(quot_2 - 10'(quot_3) * 10'd10);
   assign digits[3] = 4'(quot_3 - 7'(quot_4) * 7'd10);
   assign digits[4] = 4'(quot_4);

endmodule

FILE: design/ssd_seg_buffer.sv
// ----------------------------------------------------------------------------
// ssd_seg_buffer
// Eight-entry segment buffer: encodes a loaded number with blanking, minus
// bar and decimal point, and serves the pattern at the scan position.
// ----------------------------------------------------------------------------
module ssd_seg_buffer (
   input  logic                           clock,
   input  logic                           reset,
   input  ssd_pkg::load_req_type          load_req,
   input  logic [ssd_pkg::POS_WIDTH-1:0]  rd_addr,
   output logic [7:0]                     rd_data
);

   localparam int DIGIT_CNT = ssd_pkg::DECIMAL_DIGITS;

   ssd_pkg::buffer_type buf_ff;
   ssd_pkg::buffer_type buf_in;

   logic nz_4;
   logic nz_3;
   logic nz_2;
   logic top_4;
   logic top_3;
   logic top_2;
   logic minus;
   logic [DIGIT_CNT-1:0][7:0] pat;

   // leading digit position
   assign nz_4  = load_req.digits[4] != 4'd0;
   assign nz_3  = load_req.digits[3] != 4'd0;
   assign nz_2  = load_req.digits[2] != 4'd0;
   assign top_4 = nz_4;
   assign top_3 = !nz_4 && nz_3;
   assign top_2 = !nz_4 && !nz_3 && nz_2;
   assign minus = load_req.sign_flag == ssd_pkg::SIGN_MINUS;

   always_comb begin
      for (int i = 0; i < DIGIT_CNT; i++) begin
         pat[i] = ssd_pkg::seg_pattern(load_req.digits[i]);
      end
   end

   // next buffer contents on a load
   always_comb begin
      buf_in = buf_ff;
      if (load_req.load) begin
         buf_in[0] = pat[0];
         buf_in[1] = pat[1] | ssd_pkg::POINT_PATTERN;
         // value below 100: minus lands on position 2
         if (top_4 || top_3 || top_2) begin
            buf_in[2] = pat[2];
         end else begin
            buf_in[2] = minus ? ssd_pkg::MINUS_PATTERN : 8'h00;
         end
         if (top_4 || top_3) begin
            buf_in[3] = pat[3];
         end else begin
            buf_in[3] = (top_2 && minus) ? ssd_pkg::MINUS_PATTERN : 8'h00;
         end
         if (top_4) begin
            buf_in[4] = pat[4];
         end else begin
            buf_in[4] = (top_3 && minus) ? ssd_pkg::MINUS_PATTERN : 8'h00;
         end
         // position 5 only takes a minus above a five-digit value
         if (top_4 && minus) begin
            buf_in[5] = ssd_pkg::MINUS_PATTERN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
      end else begin
         buf_ff <= buf_in;
      end
   end

   assign rd_data = buf_ff[rd_addr];

endmodule

FILE: design/seven_segment_number_display.sv
// ----------------------------------------------------------------------------
// seven_segment_number_display
// Multiplexed seven-segment display driver: load items fill the segment
// buffer, tick items return the pattern at the scan position.
// ----------------------------------------------------------------------------
// Pipeline: a tick passes the input register, then the result register;
// its result is taken on an edge with rsp_stall low.
// Throughput: one item per cycle; the input stalls only while a tick waits
// behind a stalled result register.
// Reset: segment buffer cleared to zero, scan position zero, pipeline empty.
module seven_segment_number_display #(
   parameter int SCANNED_DIGITS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [15:0] req_number,
   input  logic        req_sign_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_digit_select,
   output logic [7:0]  rsp_segments
);

   localparam int PW = ssd_pkg::POS_WIDTH;
   localparam logic [PW:0] LAST_POS = (PW+1)'(SCANNED_DIGITS - 1);

   // input register
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic        s1_func_ff;
   logic [15:0] s1_number_ff;
   logic        s1_sign_ff;

   // result register and scan position
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [PW-1:0] rsp_pos_ff;
   logic [7:0]    rsp_seg_ff;
   logic [PW-1:0] scan_ff;
   logic [PW-1:0] scan_in;

   logic                  rsp_free;
   logic                  s1_adv;
   logic                  tick_adv;
   logic [7:0]            rd_data;
   ssd_pkg::digits_type   digits;
   ssd_pkg::load_req_type load_req;

   // handshake control
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && (s1_func_ff == ssd_pkg::FUNC_TICK) && !rsp_free;
   assign s1_adv    = s1_valid_ff && !req_stall;
   assign tick_adv  = s1_adv && (s1_func_ff == ssd_pkg::FUNC_TICK);

   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_func_ff   <= req_func;
         s1_number_ff <= req_number;
         s1_sign_ff   <= req_sign_flag;
      end
   end

   // digit split and buffer update
   ssd_digit_split u_split (
      .number (s1_number_ff),
      .digits (digits)
   );

   assign load_req.load      = s1_adv && (s1_func_ff == ssd_pkg::FUNC_LOAD);
   assign load_req.sign_flag = s1_sign_ff;
   assign load_req.digits    = digits;

   ssd_seg_buffer u_buffer (
      .clock    (clock),
      .reset    (reset),
      .load_req (load_req),
      .rd_addr  (scan_ff),
      .rd_data  (rd_data)
   );

   // scan position wraps after the last scanned digit
   always_comb begin
      scan_in = scan_ff;
      if (tick_adv) begin
         if ({1'b0, scan_ff} >= LAST_POS) begin
            scan_in = '0;
         end else begin
            scan_in = scan_ff + PW'(1);
         end
      end
   end

   // result register
   assign rsp_valid_in = tick_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_adv) begin
         rsp_pos_ff <= scan_ff;
         rsp_seg_ff <= rd_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_select = 3'(rsp_pos_ff);
   assign rsp_segments     = rsp_seg_ff;

   // scan position stays inside the scanned range
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, scan_ff} <= LAST_POS)
      else $error("scan position beyond last scanned digit");

   // input stall only comes from a blocked result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without result back-pressure");

   // a load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_func_ff == ssd_pkg::FUNC_LOAD) |=> !$rose(rsp_valid))
      else $error("result raised by a load transfer");

endmodule

FILE: bench/seven_segment_number_display_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_number_display_tb
// Drives load and tick transfers into the display driver and checks every
// returned digit select and segment pattern against a behavioral model of
// the bench's segment buffer and scan counter, or a typed row's hand-read
// result. A directed table runs first, then random bursts with random stalls
// on the result side, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module seven_segment_number_display_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         SCAN_DIGITS  = 5;
   localparam int         RESET_CYCLES = 9;
   localparam int         N_DIRECTED   = 24;
   localparam int         N_RANDOM     = 1000;
   localparam int         HOLD_AFTER   = 300;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         MAX_REPORTS  = 40;
   localparam logic       SIGN_PLAIN   = ~ssd_pkg::SIGN_MINUS;

   // segment codes for digits 9 down to 0
   localparam logic [9:0][7:0] DIGIT_SEGMENTS = {
      8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };

   typedef struct packed {
      logic [ssd_pkg::POS_WIDTH-1:0] pos;
      logic [7:0]                    seg;
   } scan_type;

   typedef struct packed {
      logic        func;
      logic [15:0] number;
      logic        sign;
      logic        typed;
      scan_type    result;
   } stim_row_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic        req_func      = ssd_pkg::FUNC_TICK;
   logic [15:0] req_number    = '0;
   logic        req_sign_flag = SIGN_PLAIN;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [2:0]  rsp_digit_select;
   logic [7:0]  rsp_segments;

   // display model state
   logic [7:0]                    seg_buffer [ssd_pkg::BUFFER_DEPTH];
   logic [ssd_pkg::POS_WIDTH-1:0] scan_pos;
   scan_type                      pending_scans [$];

   int mismatches     = 0;
   int items_accepted = 0;
   int cycle_count    = 0;

   // directed cases; typed rows carry a hand-read result
   stim_row_type directed_rows [N_DIRECTED] = '{
      // ticks straight after reset see a blank buffer
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd1, 8'h00}},
      // zero without minus: units and point digit only
      '{ssd_pkg::FUNC_LOAD, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd2, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd3, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd4, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd0, 8'h3f}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd1, 8'hbf}},
      // zero with minus: minus lands on position 2
      '{ssd_pkg::FUNC_LOAD, 16'd0,     ssd_pkg::SIGN_MINUS, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd2, 8'h40}},
      // full scale with minus: minus goes above the scanned range
      '{ssd_pkg::FUNC_LOAD, 16'd65535, ssd_pkg::SIGN_MINUS, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd3, 8'h6d}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b1, '{3'd4, 8'h7d}},
      // two-digit value with minus, then the scan wraps
      '{ssd_pkg::FUNC_LOAD, 16'd99,    ssd_pkg::SIGN_MINUS, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      // three digits with minus above the hundreds
      '{ssd_pkg::FUNC_LOAD, 16'd100,   ssd_pkg::SIGN_MINUS, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      // five digits, no minus, upper positions kept
      '{ssd_pkg::FUNC_LOAD, 16'd12345, SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      // four digits with minus on the top scanned position
      '{ssd_pkg::FUNC_LOAD, 16'd1000,  ssd_pkg::SIGN_MINUS, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}},
      '{ssd_pkg::FUNC_TICK, 16'd0,     SIGN_PLAIN, 1'b0, '{3'd0, 8'h00}}
   };

   seven_segment_number_display #(
      .SCANNED_DIGITS(SCAN_DIGITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_number      (req_number),
      .req_sign_flag   (req_sign_flag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digit_select(rsp_digit_select),
      .rsp_segments    (rsp_segments)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
      mismatches++;
   endtask

   // split into decimal digits, blank leading zeros, place minus and point
   task automatic predict_load(input logic [15:0] value, input logic sign);
      logic [3:0] dig [ssd_pkg::DECIMAL_DIGITS];
      int         remaining;
      int         top;
      bit         found;
      remaining = value;
      top       = 1;
      found     = 1'b0;
      for (int p = 0; p < ssd_pkg::DECIMAL_DIGITS; p++) begin
         dig[p]    = 4'(remaining % 10);
         remaining = remaining / 10;
      end
      for (int p = 4; p >= 2 && !found; p--) begin
         if (dig[p] != 4'd0) begin
            top   = p;
            found = 1'b1;
         end else begin
            seg_buffer[p] = 8'h00;
         end
      end
      // with no leading digit found, top stays 1 and minus lands on 2
      if (sign == ssd_pkg::SIGN_MINUS) begin
         seg_buffer[top + 1] = ssd_pkg::MINUS_PATTERN;
      end
      for (int p = top; p >= 0; p--) begin
         seg_buffer[p] = DIGIT_SEGMENTS[dig[p]];
      end
      seg_buffer[1] = seg_buffer[1] | ssd_pkg::POINT_PATTERN;
   endtask

   // current position and pattern, then advance with wrap
   task automatic predict_tick(output scan_type res);
      res.pos = scan_pos;
      res.seg = seg_buffer[scan_pos];
      if (int'(scan_pos) + 1 >= SCAN_DIGITS) begin
         scan_pos = '0;
      end else begin
         scan_pos = scan_pos + 1'b1;
      end
   endtask

   // offer one item and hold it until the transfer
   task automatic send_item(input stim_row_type row);
      scan_type predicted;
      req_valid     <= 1'b1;
      req_func      <= row.func;
      req_number    <= row.number;
      req_sign_flag <= row.sign;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_accepted++;
      if (row.func == ssd_pkg::FUNC_LOAD) begin
         predict_load(row.number, row.sign);
      end else begin
         predict_tick(predicted);
         pending_scans.push_back(row.typed ? row.result : predicted);
      end
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic stim_row_type random_row();
      stim_row_type r;
      r      = '0;
      r.func = ($urandom_range(0, 9) < 6) ? ssd_pkg::FUNC_TICK : ssd_pkg::FUNC_LOAD;
      // mostly short values so blanking and minus placement vary
      case ($urandom_range(0, 5))
         0:       r.number = 16'($urandom_range(0, 9));
         1:       r.number = 16'($urandom_range(0, 99));
         2:       r.number = 16'($urandom_range(0, 999));
         3:       r.number = 16'($urandom_range(0, 9999));
         4:       r.number = 16'($urandom);
         default: r.number = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      endcase
      r.sign = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // sender: reset, directed table, then random bursts
   initial begin : stimulus
      stim_row_type row;
      int           burst_left;
      for (int k = 0; k < ssd_pkg::BUFFER_DEPTH; k++) begin
         seg_buffer[k] = 8'h00;
      end
      scan_pos   = '0;
      burst_left = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
         if ($urandom_range(0, 3) == 0) begin
            idle_gap($urandom_range(1, 4));
         end
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
               idle_gap($urandom_range(1, 8));
            end
         end
         burst_left--;
         row = random_row();
         send_item(row);
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the pipeline settle
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // receiver stall pattern with one long hold-off
   initial begin : receiver
      int mode;
      int seg_len;
      bit held;
      held = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held && items_accepted >= HOLD_AFTER) begin
            held = 1'b1;
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         seg_len = $urandom_range(5, 60);
         repeat (seg_len) begin
            @(posedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // compare each result transfer with the oldest expected scan
   always @(posedge clock) begin : scan_checker
      scan_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_scans.size() == 0) begin
            report_mismatch($sformatf("unexpected result: select %0d segments %02h",
                                      rsp_digit_select, rsp_segments));
         end else begin
            want = pending_scans.pop_front();
            if (rsp_digit_select !== want.pos) begin
               report_mismatch($sformatf("digit_select %0d, expected %0d",
                                         rsp_digit_select, want.pos));
            end
            if (rsp_segments !== want.seg) begin
               report_mismatch($sformatf("segments %02h at select %0d, expected %02h",
                                         rsp_segments, want.pos, want.seg));
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_scans.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
